### src/touch_contact_lifecycle_assert.svh
// Assertion macros for the touch contact lifecycle block.
// Each macro takes a label, clock, active-low reset, antecedent and consequent.
`ifndef TOUCH_CONTACT_LIFECYCLE_ASSERT_SVH
`define TOUCH_CONTACT_LIFECYCLE_ASSERT_SVH

`ifndef SYNTHESIS

`define TCL_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("touch_contact_lifecycle: same-cycle check failed");

`define TCL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("touch_contact_lifecycle: next-cycle check failed");

`else

`define TCL_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define TCL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

### src/tcl_pkg.sv
package tcl_pkg;

    localparam int ID_W         = 4;
    localparam int DATA_W       = 64;
    localparam int ID_COUNT     = 16;
    localparam int MAX_CONTACTS = 16;
    localparam int COUNT_W      = 5;

    localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(31);
    localparam logic [COUNT_W-1:0] CAPACITY  = COUNT_W'(MAX_CONTACTS);
    localparam logic [ID_W-1:0]    ID_LAST   = ID_W'(ID_COUNT - 1);

    typedef enum logic [1:0] {
        ACT_CONTACT   = 2'd0,
        ACT_FRAME_END = 2'd1,
        ACT_FLUSH     = 2'd2,
        ACT_NONE      = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_TOUCH = 2'd1,
        KIND_END   = 2'd2,
        KIND_DONE  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_READ,
        S_EMIT,
        S_DONE
    } t_state;

    typedef struct packed {
        t_kind              kind;
        logic [ID_W-1:0]    id;
        logic [DATA_W-1:0]  data;
        logic               last;
        logic               any_ended;
    } t_result;

    typedef struct packed {
        logic               we;
        logic [ID_W-1:0]    waddr;
        logic [DATA_W-1:0]  wdata;
        logic               re;
        logic [ID_W-1:0]    raddr;
    } t_ram_req;

endpackage

### src/tcl_ram.sv
module tcl_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/tcl_ctrl.sv
// Sequencer: presence sets, frame counter, id scan and payload store.
module tcl_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [1:0]                  i_action,
    input  logic [tcl_pkg::ID_W-1:0]    i_contact_id,
    input  logic [tcl_pkg::DATA_W-1:0]  i_contact_data,
    output logic                        o_res_valid,
    input  logic                        i_res_ready,
    output tcl_pkg::t_result            o_res
);

    tcl_pkg::t_state                      r_state, n_state;
    logic [tcl_pkg::ID_COUNT-1:0]         r_prev, n_prev;
    logic [tcl_pkg::ID_COUNT-1:0]         r_cur, n_cur;
    logic [tcl_pkg::ID_COUNT-1:0]         r_mask, n_mask;
    logic [tcl_pkg::COUNT_W-1:0]          r_count, n_count;
    logic [tcl_pkg::COUNT_W-1:0]          r_total, n_total;
    logic [tcl_pkg::ID_W-1:0]             r_idx, n_idx;
    logic                                 r_flush, n_flush;
    logic                                 r_any, n_any;
    tcl_pkg::t_result                     r_res, n_res;

    tcl_pkg::t_ram_req                    ram_req;
    logic [tcl_pkg::DATA_W-1:0]           ram_rdata;
    logic                                 w_hit;
    logic                                 w_accept;
    tcl_pkg::t_action                     w_action;

    assign w_action = tcl_pkg::t_action'(i_action);
    assign w_accept = i_in_valid && (r_state == tcl_pkg::S_IDLE);
    // shared compare: id still to end, and capacity left unless flushing
    assign w_hit    = r_mask[r_idx] && (r_flush || (r_total < tcl_pkg::CAPACITY));

    tcl_ram #(
        .WIDTH (tcl_pkg::DATA_W),
        .DEPTH (tcl_pkg::ID_COUNT)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_re    (ram_req.re),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tcl_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    case (w_action)
                        tcl_pkg::ACT_CONTACT:   n_state = tcl_pkg::S_EMIT;
                        tcl_pkg::ACT_FRAME_END: n_state = tcl_pkg::S_SCAN;
                        tcl_pkg::ACT_FLUSH:     n_state = tcl_pkg::S_SCAN;
                        default:                n_state = tcl_pkg::S_IDLE;
                    endcase
                end
            end
            tcl_pkg::S_SCAN: begin
                if (w_hit) begin
                    n_state = tcl_pkg::S_READ;
                end else if (r_idx == tcl_pkg::ID_LAST) begin
                    n_state = tcl_pkg::S_DONE;
                end
            end
            tcl_pkg::S_READ: begin
                n_state = tcl_pkg::S_EMIT;
            end
            tcl_pkg::S_EMIT: begin
                if (i_res_ready) begin
                    if (r_res.last) begin
                        n_state = tcl_pkg::S_IDLE;
                    end else if (r_idx == tcl_pkg::ID_LAST) begin
                        n_state = tcl_pkg::S_DONE;
                    end else begin
                        n_state = tcl_pkg::S_SCAN;
                    end
                end
            end
            tcl_pkg::S_DONE: begin
                n_state = tcl_pkg::S_EMIT;
            end
            default: n_state = tcl_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready    = (r_state == tcl_pkg::S_IDLE);
        o_res_valid   = (r_state == tcl_pkg::S_EMIT);
        ram_req.we    = w_accept && (w_action == tcl_pkg::ACT_CONTACT);
        ram_req.waddr = i_contact_id;
        ram_req.wdata = i_contact_data;
        ram_req.re    = (r_state == tcl_pkg::S_SCAN) && w_hit;
        ram_req.raddr = r_idx;
    end

    assign o_res = r_res;

    // datapath
    always_comb begin
        n_prev  = r_prev;
        n_cur   = r_cur;
        n_mask  = r_mask;
        n_count = r_count;
        n_total = r_total;
        n_idx   = r_idx;
        n_flush = r_flush;
        n_any   = r_any;
        n_res   = r_res;
        case (r_state)
            tcl_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    case (w_action)
                        tcl_pkg::ACT_CONTACT: begin
                            n_cur = r_cur | (tcl_pkg::ID_COUNT'(1) << i_contact_id);
                            if (r_count < tcl_pkg::COUNT_MAX) begin
                                n_count = r_count + 1'b1;
                            end
                            n_res.kind = r_prev[i_contact_id] ? tcl_pkg::KIND_TOUCH
                                                              : tcl_pkg::KIND_START;
                            n_res.id        = i_contact_id;
                            n_res.data      = i_contact_data;
                            n_res.last      = 1'b1;
                            n_res.any_ended = 1'b0;
                        end
                        tcl_pkg::ACT_FRAME_END: begin
                            n_mask  = r_prev & ~r_cur;
                            n_total = r_count;
                            n_flush = 1'b0;
                            n_any   = 1'b0;
                            n_idx   = '0;
                            n_prev  = r_cur;
                            n_cur   = '0;
                            n_count = '0;
                        end
                        tcl_pkg::ACT_FLUSH: begin
                            n_mask  = r_prev;
                            n_total = '0;
                            n_flush = 1'b1;
                            n_any   = 1'b0;
                            n_idx   = '0;
                            n_prev  = '0;
                            n_cur   = '0;
                            n_count = '0;
                        end
                        default: ;
                    endcase
                end
            end
            tcl_pkg::S_SCAN: begin
                if (!w_hit) begin
                    n_idx = r_idx + 1'b1;
                end
            end
            tcl_pkg::S_READ: begin
                n_res.kind      = tcl_pkg::KIND_END;
                n_res.id        = r_idx;
                n_res.data      = ram_rdata;
                n_res.last      = 1'b0;
                n_res.any_ended = 1'b0;
                n_any           = 1'b1;
            end
            tcl_pkg::S_EMIT: begin
                if (i_res_ready && !r_res.last) begin
                    n_total = r_total + 1'b1;
                    n_idx   = r_idx + 1'b1;
                end
            end
            tcl_pkg::S_DONE: begin
                n_res.kind      = tcl_pkg::KIND_DONE;
                n_res.id        = '0;
                n_res.data      = '0;
                n_res.last      = 1'b1;
                n_res.any_ended = r_flush && r_any;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tcl_pkg::S_IDLE;
            r_prev  <= '0;
            r_cur   <= '0;
            r_count <= '0;
            r_total <= '0;
            r_idx   <= '0;
            r_flush <= 1'b0;
            r_any   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_prev  <= n_prev;
            r_cur   <= n_cur;
            r_count <= n_count;
            r_total <= n_total;
            r_idx   <= n_idx;
            r_flush <= n_flush;
            r_any   <= n_any;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mask <= n_mask;
        r_res  <= n_res;
    end

endmodule

### src/touch_contact_lifecycle.sv
// Touch contact lifecycle tracker.
// Input channel (i_in_valid / o_in_ready): one transfer carries action, id and
// payload. Contact items come back as start or touching; a frame-end item
// scans ids 0..15 and ends the ones that vanished (capped by frame capacity),
// a flush ends every carried-over id. Each frame-end or flush run closes with a done marker.
// Output channel (o_out_valid / i_out_ready): one result per transfer, with
// o_last_of_run high on the last result caused by an item.
// A contact result is first registered in the sequencer, then moved into the
// output register; the next item can go in once that result has been handed
// to the output register.
// A frame end or flush scans the ids in order, one id per cycle through the
// shared bit-test/capacity compare, paused while an end event is read from
// the payload store and emitted; after the last id the done marker is
// emitted. The payload store has a single read port.
// Input is not ready while an item is in progress; action 3 is taken and
// dropped with no result.
// Stall: the output register holds its result until taken; the sequencer
// parks on the next result, nothing is lost or repeated.
// Reset (synchronous, active low) clears both presence sets, the frame
// counter and the sequencer; the payload store is not cleared.
`include "touch_contact_lifecycle_assert.svh"

module touch_contact_lifecycle (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [1:0]                  i_action,
    input  logic [tcl_pkg::ID_W-1:0]    i_contact_id,
    input  logic [tcl_pkg::DATA_W-1:0]  i_contact_data,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [1:0]                  o_kind,
    output logic [tcl_pkg::ID_W-1:0]    o_out_id,
    output logic [tcl_pkg::DATA_W-1:0]  o_out_data,
    output logic                        o_last_of_run,
    output logic                        o_any_ended
);

    logic             res_valid;
    logic             res_ready;
    tcl_pkg::t_result res;

    logic             r_out_valid, n_out_valid;
    tcl_pkg::t_result r_out;

    tcl_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_action       (i_action),
        .i_contact_id   (i_contact_id),
        .i_contact_data (i_contact_data),
        .o_res_valid    (res_valid),
        .i_res_ready    (res_ready),
        .o_res          (res)
    );

    // output register: load when empty or being drained this cycle
    assign res_ready = !r_out_valid || i_out_ready;

    always_comb begin
        n_out_valid = r_out_valid;
        if (res_ready) begin
            n_out_valid = res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_out.kind;
    assign o_out_id      = r_out.id;
    assign o_out_data    = r_out.data;
    assign o_last_of_run = r_out.last;
    assign o_any_ended   = r_out.any_ended;

    // sequencer never takes an item while a result is pending
    `TCL_ASSERT_NOW(a_ready_excl, i_clk, i_rst_n, o_in_ready, !res_valid)
    // a real item always makes the block busy on the next cycle
    `TCL_ASSERT_NEXT(a_busy_after, i_clk, i_rst_n, i_in_valid && o_in_ready && (i_action != tcl_pkg::ACT_NONE), !o_in_ready)
    // done markers close a run, end events never do
    `TCL_ASSERT_NOW(a_done_last, i_clk, i_rst_n, o_out_valid && (o_kind == tcl_pkg::KIND_DONE), o_last_of_run)
    `TCL_ASSERT_NOW(a_end_open, i_clk, i_rst_n, o_out_valid && (o_kind == tcl_pkg::KIND_END), !o_last_of_run)
    // any_ended only rides on a done marker
    `TCL_ASSERT_NOW(a_any_done, i_clk, i_rst_n, r_out_valid && r_out.any_ended, r_out.kind == tcl_pkg::KIND_DONE)

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int ID_W         = tcl_pkg::ID_W;
    localparam int DATA_W       = tcl_pkg::DATA_W;
    localparam int ID_COUNT     = tcl_pkg::ID_COUNT;
    localparam int COUNT_W      = tcl_pkg::COUNT_W;
    localparam int MAX_CONTACTS = tcl_pkg::MAX_CONTACTS;

    localparam int RANDOM_ITEMS = 130;
    localparam int CALM_TAIL    = 30;      // final items run with no idling on either side
    localparam int PRESSURE_AT  = 60;      // random item count at which the long hold starts
    localparam int LONG_HOLD    = 120;     // receiver hold-off, in cycles
    localparam int DRAIN_CYCLES = 80;      // > one full scan with every id ending
    localparam int CYCLE_LIMIT  = 400000;

    localparam logic [DATA_W-1:0] DATA_ONES = '1;
    localparam logic [DATA_W-1:0] DATA_ALT5 = 64'h5555_5555_5555_5555;
    localparam logic [DATA_W-1:0] DATA_ALTA = 64'hAAAA_AAAA_AAAA_AAAA;

    typedef tcl_pkg::t_action t_action;
    typedef tcl_pkg::t_kind   t_kind;
    typedef tcl_pkg::t_result t_result;

    // one directed row; reps > 1 repeats a contact with the payload counting up
    typedef struct {
        t_action           act;
        logic [ID_W-1:0]   id;
        logic [DATA_W-1:0] data;
        int                reps;
        bit                pinned;     // want holds the typed-in single result
        t_result           want;
    } t_stim_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [1:0]           i_action;
    logic [ID_W-1:0]      i_contact_id;
    logic [DATA_W-1:0]    i_contact_data;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [1:0]           o_kind;
    logic [ID_W-1:0]      o_out_id;
    logic [DATA_W-1:0]    o_out_data;
    logic                 o_last_of_run;
    logic                 o_any_ended;

    // contact tracking state mirrored by the predictor
    logic [ID_COUNT-1:0]  seen_prev;
    logic [ID_COUNT-1:0]  seen_now;
    logic [DATA_W-1:0]    last_payload [ID_COUNT];
    logic [COUNT_W-1:0]   frame_contacts;

    t_result              pending_events [$];
    t_stim_row            dir_table [$];

    // traffic shaping shared between the sender, receiver and sequencer
    bit                   tx_idle;
    bit                   rx_idle;
    bit                   hold_req;

    int unsigned          cycle_count;
    int unsigned          items_accepted;
    int unsigned          results_seen;
    int unsigned          ends_seen;
    int unsigned          mismatches;

    touch_contact_lifecycle uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_action       (i_action),
        .i_contact_id   (i_contact_id),
        .i_contact_data (i_contact_data),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_kind         (o_kind),
        .o_out_id       (o_out_id),
        .o_out_data     (o_out_data),
        .o_last_of_run  (o_last_of_run),
        .o_any_ended    (o_any_ended)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor: contact labelling, frame-end scan and flush
    // ------------------------------------------------------------------
    task automatic post_event(input t_kind k, input logic [ID_W-1:0] id,
                              input logic [DATA_W-1:0] d, input logic last,
                              input logic any);
        t_result r;
        r.kind      = k;
        r.id        = id;
        r.data      = d;
        r.last      = last;
        r.any_ended = any;
        pending_events.push_back(r);
    endtask

    task automatic track_contacts(input t_action act, input logic [ID_W-1:0] id,
                                  input logic [DATA_W-1:0] data);
        int total;
        int ended;
        t_kind k;
        logic [ID_W-1:0] idx;
        case (act)
            tcl_pkg::ACT_CONTACT: begin
                k = seen_prev[id] ? tcl_pkg::KIND_TOUCH : tcl_pkg::KIND_START;
                seen_now[id]     = 1'b1;
                last_payload[id] = data;
                if (frame_contacts < tcl_pkg::COUNT_MAX) frame_contacts++;
                post_event(k, id, data, 1'b1, 1'b0);
            end
            tcl_pkg::ACT_FRAME_END: begin
                // ends for vanished ids, only while the frame total is under capacity
                total = int'(frame_contacts);
                for (int i = 0; i < ID_COUNT; i++) begin
                    idx = ID_W'(i);
                    if (seen_prev[idx] && !seen_now[idx] && total < MAX_CONTACTS) begin
                        post_event(tcl_pkg::KIND_END, idx, last_payload[idx], 1'b0, 1'b0);
                        total++;
                    end
                end
                post_event(tcl_pkg::KIND_DONE, '0, '0, 1'b1, 1'b0);
                seen_prev      = seen_now;
                seen_now       = '0;
                frame_contacts = '0;
            end
            tcl_pkg::ACT_FLUSH: begin
                // no capacity limit; the unfinished frame is dropped
                ended = 0;
                for (int i = 0; i < ID_COUNT; i++) begin
                    idx = ID_W'(i);
                    if (seen_prev[idx]) begin
                        post_event(tcl_pkg::KIND_END, idx, last_payload[idx], 1'b0, 1'b0);
                        ended++;
                    end
                end
                post_event(tcl_pkg::KIND_DONE, '0, '0, 1'b1, ended > 0);
                seen_prev      = '0;
                seen_now       = '0;
                frame_contacts = '0;
            end
            default: ;  // unused action: no result, no state change
        endcase
    endtask

    // ------------------------------------------------------------------
    // Sender: payload changes at the falling edge, transfer seen at the rising edge
    // ------------------------------------------------------------------
    task automatic send_item(input t_action act, input logic [ID_W-1:0] id,
                             input logic [DATA_W-1:0] data);
        int gap;
        @(negedge i_clk);
        if (tx_idle && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 9);
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid     = 1'b1;
        i_action       = act;
        i_contact_id   = id;
        i_contact_data = data;
        do @(posedge i_clk); while (!o_in_ready);
        items_accepted++;
        track_contacts(act, id, data);
    endtask

    function automatic logic [DATA_W-1:0] rand_payload();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return DATA_ONES;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // mostly reuse ids of the last frame so touching and capped ends show up
    function automatic logic [ID_W-1:0] pick_id();
        int i;
        if (seen_prev != '0 && $urandom_range(0, 9) < 7) begin
            do i = $urandom_range(0, ID_COUNT - 1); while (!seen_prev[ID_W'(i)]);
            return ID_W'(i);
        end
        return ID_W'($urandom_range(0, ID_COUNT - 1));
    endfunction

    // ------------------------------------------------------------------
    // Receiver: random stall bursts, plus one long hold-off on request
    // ------------------------------------------------------------------
    initial begin : out_ready_ctl
        int stall_left;
        bit hold_done;
        stall_left  = 0;
        hold_done   = 1'b0;
        i_out_ready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (stall_left == 0) begin
                if (hold_req && !hold_done) begin
                    stall_left = LONG_HOLD;
                    hold_done  = 1'b1;
                end else if (rx_idle && $urandom_range(0, 5) == 0) begin
                    stall_left = $urandom_range(1, 9);
                end
            end
            if (stall_left > 0) begin
                i_out_ready = 1'b0;
                stall_left--;
            end else begin
                i_out_ready = 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker: each result transfer against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check_results
        t_result want;
        bit bad;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (pending_events.size() == 0) begin
                mismatches++;
                $display("%0t: result expected none, actual kind %0d id %0d data %h",
                         $realtime, o_kind, o_out_id, o_out_data);
            end else begin
                want = pending_events.pop_front();
                bad  = 1'b0;
                if (want.kind == tcl_pkg::KIND_END) ends_seen++;
                if (o_kind !== want.kind) begin
                    bad = 1'b1;
                    $display("%0t: kind expected %0d, actual %0d",
                             $realtime, want.kind, o_kind);
                end
                if (o_out_id !== want.id) begin
                    bad = 1'b1;
                    $display("%0t: out_id expected %0d, actual %0d",
                             $realtime, want.id, o_out_id);
                end
                if (o_out_data !== want.data) begin
                    bad = 1'b1;
                    $display("%0t: out_data expected %h, actual %h",
                             $realtime, want.data, o_out_data);
                end
                if (o_last_of_run !== want.last) begin
                    bad = 1'b1;
                    $display("%0t: last_of_run expected %0b, actual %0b",
                             $realtime, want.last, o_last_of_run);
                end
                if (o_any_ended !== want.any_ended) begin
                    bad = 1'b1;
                    $display("%0t: any_ended expected %0b, actual %0b",
                             $realtime, want.any_ended, o_any_ended);
                end
                if (bad) mismatches++;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: run did not finish within %0d cycles, %0d results outstanding",
                     $realtime, CYCLE_LIMIT, pending_events.size());
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    initial begin : sequencer
        t_stim_row row;
        t_action   close_act;
        int        sent;
        int        roll;
        int        n;
        bit        pressure_done;

        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_action       = tcl_pkg::ACT_NONE;
        i_contact_id   = '0;
        i_contact_data = '0;
        tx_idle        = 1'b1;
        rx_idle        = 1'b1;
        hold_req       = 1'b0;
        items_accepted = 0;
        seen_prev      = '0;
        seen_now       = '0;
        frame_contacts = '0;
        for (int i = 0; i < ID_COUNT; i++) last_payload[ID_W'(i)] = '0;
        sent           = 0;
        pressure_done  = 1'b0;

        // Directed table. Pinned rows carry the one result they must give;
        // the rest rely on the predictor.
        // flush and frame end with nothing tracked yet
        dir_table.push_back('{tcl_pkg::ACT_FLUSH, 4'd0, 64'd0, 1, 1'b1,
                              '{tcl_pkg::KIND_DONE, 4'd0, 64'd0, 1'b1, 1'b0}});
        dir_table.push_back('{tcl_pkg::ACT_FRAME_END, 4'd0, 64'd0, 1, 1'b1,
                              '{tcl_pkg::KIND_DONE, 4'd0, 64'd0, 1'b1, 1'b0}});
        // unused action: dropped silently
        dir_table.push_back('{tcl_pkg::ACT_NONE, 4'd15, DATA_ONES, 1, 1'b0, '0});
        // extreme ids and payloads, then a repeated id in one frame
        dir_table.push_back('{tcl_pkg::ACT_CONTACT, 4'd0, 64'd0, 1, 1'b1,
                              '{tcl_pkg::KIND_START, 4'd0, 64'd0, 1'b1, 1'b0}});
        dir_table.push_back('{tcl_pkg::ACT_CONTACT, 4'd15, DATA_ONES, 1, 1'b1,
                              '{tcl_pkg::KIND_START, 4'd15, DATA_ONES, 1'b1, 1'b0}});
        dir_table.push_back('{tcl_pkg::ACT_CONTACT, 4'd15, DATA_ALT5, 1, 1'b1,
                              '{tcl_pkg::KIND_START, 4'd15, DATA_ALT5, 1'b1, 1'b0}});
        dir_table.push_back('{tcl_pkg::ACT_FRAME_END, 4'd0, 64'd0, 1, 1'b1,
                              '{tcl_pkg::KIND_DONE, 4'd0, 64'd0, 1'b1, 1'b0}});
        // id 0 carries on, id 15 vanishes with its latest payload
        dir_table.push_back('{tcl_pkg::ACT_CONTACT, 4'd0, DATA_ALTA, 1, 1'b1,
                              '{tcl_pkg::KIND_TOUCH, 4'd0, DATA_ALTA, 1'b1, 1'b0}});
        dir_table.push_back('{tcl_pkg::ACT_FRAME_END, 4'd0, 64'd0, 1, 1'b0, '0});
        // flush mid-frame: id 7 of the open frame is discarded
        dir_table.push_back('{tcl_pkg::ACT_CONTACT, 4'd7, 64'h0123_4567_89AB_CDEF, 1, 1'b1,
                              '{tcl_pkg::KIND_START, 4'd7, 64'h0123_4567_89AB_CDEF,
                                1'b1, 1'b0}});
        dir_table.push_back('{tcl_pkg::ACT_FLUSH, 4'd9, DATA_ONES, 1, 1'b0, '0});
        dir_table.push_back('{tcl_pkg::ACT_FRAME_END, 4'd0, 64'd0, 1, 1'b1,
                              '{tcl_pkg::KIND_DONE, 4'd0, 64'd0, 1'b1, 1'b0}});
        // four ids, then a crowded frame that leaves room for two ends only
        dir_table.push_back('{tcl_pkg::ACT_CONTACT, 4'd1, 64'h1111, 1, 1'b1,
                              '{tcl_pkg::KIND_START, 4'd1, 64'h1111, 1'b1, 1'b0}});
        dir_table.push_back('{tcl_pkg::ACT_CONTACT, 4'd2, 64'h2222, 1, 1'b1,
                              '{tcl_pkg::KIND_START, 4'd2, 64'h2222, 1'b1, 1'b0}});
        dir_table.push_back('{tcl_pkg::ACT_CONTACT, 4'd3, 64'h3333, 1, 1'b1,
                              '{tcl_pkg::KIND_START, 4'd3, 64'h3333, 1'b1, 1'b0}});
        dir_table.push_back('{tcl_pkg::ACT_CONTACT, 4'd9, 64'h9999, 1, 1'b1,
                              '{tcl_pkg::KIND_START, 4'd9, 64'h9999, 1'b1, 1'b0}});
        dir_table.push_back('{tcl_pkg::ACT_FRAME_END, 4'd0, 64'd0, 1, 1'b1,
                              '{tcl_pkg::KIND_DONE, 4'd0, 64'd0, 1'b1, 1'b0}});
        dir_table.push_back('{tcl_pkg::ACT_CONTACT, 4'd0, 64'h100, 14, 1'b0, '0});
        dir_table.push_back('{tcl_pkg::ACT_FRAME_END, 4'd0, 64'd0, 1, 1'b0, '0});
        // over capacity: counter saturates, no ends at all in that frame
        dir_table.push_back('{tcl_pkg::ACT_CONTACT, 4'd4, 64'h400, 33, 1'b0, '0});
        dir_table.push_back('{tcl_pkg::ACT_FRAME_END, 4'd0, 64'd0, 1, 1'b0, '0});
        dir_table.push_back('{tcl_pkg::ACT_FLUSH, 4'd0, 64'd0, 1, 1'b0, '0});
        dir_table.push_back('{tcl_pkg::ACT_NONE, 4'd0, 64'd0, 1, 1'b0, '0});

        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_table[r]) begin
            row = dir_table[r];
            for (int k = 0; k < row.reps; k++)
                send_item(row.act, row.id, row.data + DATA_W'(k));
            if (row.pinned) pending_events[pending_events.size() - 1] = row.want;
        end

        // Random part: well-formed frames with random content, some crowded,
        // some cut short by a flush, plus stray flushes and unused actions.
        while (sent < RANDOM_ITEMS) begin
            if (sent >= RANDOM_ITEMS - CALM_TAIL) begin
                tx_idle = 1'b0;
                rx_idle = 1'b0;
            end else if ($urandom_range(0, 7) == 0) begin
                tx_idle = 1'($urandom_range(0, 1));
                rx_idle = 1'($urandom_range(0, 1));
            end
            if (!pressure_done && sent >= PRESSURE_AT) begin
                hold_req      = 1'b1;
                pressure_done = 1'b1;
            end
            roll = $urandom_range(0, 99);
            if (roll < 4) begin
                send_item(tcl_pkg::ACT_NONE, ID_W'($urandom), rand_payload());
            end else if (roll < 10) begin
                send_item(tcl_pkg::ACT_FLUSH, ID_W'($urandom), rand_payload());
                sent++;
            end else begin
                n = (roll < 20) ? $urandom_range(12, 20) : $urandom_range(0, 5);
                repeat (n) begin
                    send_item(tcl_pkg::ACT_CONTACT, pick_id(), rand_payload());
                    sent++;
                end
                close_act = ($urandom_range(0, 9) == 0) ? tcl_pkg::ACT_FLUSH
                                                        : tcl_pkg::ACT_FRAME_END;
                send_item(close_act, ID_W'($urandom), rand_payload());
                sent++;
            end
        end

        @(negedge i_clk);
        i_in_valid = 1'b0;

        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d accepted items (%0d directed rows, %0d random), %0d results",
                 items_accepted, dir_table.size(), sent, results_seen);
        $display("including %0d end events; one long output hold-off applied", ends_seen);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### touch_contact_lifecycle.f
+incdir+src
src/tcl_pkg.sv
src/tcl_ram.sv
src/tcl_ctrl.sv
src/touch_contact_lifecycle.sv
dv/tb_top.sv
